>>> src/fcc_pkg.sv
// Package with shared types and constants for the frame checker.
`default_nettype none

package fcc_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [1:0] REG_START_BYTE = 2'd0;
   localparam logic [1:0] REG_HOST_ADDR  = 2'd1;
   localparam logic [1:0] REG_TERM_ADDR  = 2'd2;

   localparam logic [7:0] START_BYTE_RESET = 8'd123;
   localparam logic [7:0] END_MARK         = 8'hFD;

   localparam logic [4:0] POS_VERSION    = 5'd1;
   localparam logic [4:0] POS_SOURCE_END = 5'd7;
   localparam logic [4:0] POS_DEST_END   = 5'd13;
   localparam logic [4:0] POS_MSG_ID     = 5'd14;
   localparam logic [4:0] POS_LEN_LO     = 5'd15;
   localparam logic [4:0] POS_LEN_HI     = 5'd16;
   localparam logic [4:0] POS_MSG_TYPE   = 5'd17;
   localparam logic [4:0] POS_SUM_END    = 5'd23;
   localparam logic [4:0] POS_HDR_CHECK  = 5'd24;

   localparam logic [16:0] FRAME_OVERHEAD = 17'd28;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ADDR_BAD  = 3'd1;
   localparam logic [2:0] ST_HDR_BAD   = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_BODY_BAD  = 3'd4;
   localparam logic [2:0] ST_END_BAD   = 3'd5;

   typedef enum logic [5:0] {
      PH_HUNT         = 6'b000001,
      PH_HEAD         = 6'b000010,
      PH_BODY         = 6'b000100,
      PH_TAIL_OK      = 6'b001000,
      PH_TAIL_BODYBAD = 6'b010000,
      PH_TAIL_ENDBAD  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [47:0] host_address;
      logic [47:0] terminal_address;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  version;
      logic [7:0]  message_id;
      logic [7:0]  message_type;
      logic [15:0] body_length;
      logic [16:0] frame_length;
      logic [47:0] time_tag;
   } result_type;

   typedef struct packed {
      logic hunting;
      logic skipping;
   } flags_type;

endpackage

`default_nettype wire

>>> src/fcc_csr.sv
// Configuration registers of the frame checker on an APB-style port.
`default_nettype none

module fcc_csr
   import fcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      cfg_type               cfg
);

   logic [7:0]  start_ff, start_in;
   logic [47:0] host_ff, host_in;
   logic [47:0] term_ff, term_in;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[4:3];

   always_comb begin
      start_in = start_ff;
      host_in  = host_ff;
      term_in  = term_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_START_BYTE: start_in = pwdata[7:0];
            REG_HOST_ADDR:  host_in  = pwdata[47:0];
            REG_TERM_ADDR:  term_in  = pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_BYTE_RESET;
         host_ff  <= '0;
         term_ff  <= '0;
      end else begin
         start_ff <= start_in;
         host_ff  <= host_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_START_BYTE: prdata = {56'd0, start_ff};
         REG_HOST_ADDR:  prdata = {16'd0, host_ff};
         REG_TERM_ADDR:  prdata = {16'd0, term_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.start_byte       = start_ff;
   assign cfg.host_address     = host_ff;
   assign cfg.terminal_address = term_ff;

endmodule

`default_nettype wire

>>> src/fcc_parser.sv
// Per-byte frame parser: phase, counters, checksums and captured header fields.
`default_nettype none

module fcc_parser
   import fcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] rx_byte,
   input  wire logic       buffer_end,
   input  wire cfg_type    cfg,
   output      logic       emit,
   output      result_type result,
   output      flags_type  flags
);

   phase_type   phase_ff, phase_in, tail_phase;
   logic        skip_ff, skip_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in, sum_plus;
   logic [47:0] source_ff, source_in;
   logic [47:0] dest_ff, dest_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  msg_id_ff, msg_id_in;
   logic [7:0]  msg_type_ff, msg_type_in;
   logic [47:0] time_ff, time_in;
   logic [4:0]  pos;
   logic        open_frame;
   logic        hit;
   logic [2:0]  status;

   assign sum_plus = sum_ff + rx_byte;
   assign pos      = count_ff[4:0] + 5'd1;

   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      source_in   = source_ff;
      dest_in     = dest_ff;
      length_in   = length_ff;
      version_in  = version_ff;
      msg_id_in   = msg_id_ff;
      msg_type_in = msg_type_ff;
      time_in     = time_ff;
      tail_phase  = phase_ff;
      open_frame  = 1'b1;
      hit         = 1'b0;
      status      = ST_OK;
      if (take) begin
         if (skip_ff) begin
            open_frame = 1'b0;
            if (buffer_end) begin
               skip_in = 1'b0;
            end
         end else begin
            unique case (phase_ff) inside
               PH_HUNT: begin
                  if (rx_byte == cfg.start_byte) begin
                     phase_in    = PH_HEAD;
                     count_in    = '0;
                     sum_in      = '0;
                     source_in   = '0;
                     dest_in     = '0;
                     length_in   = '0;
                     version_in  = '0;
                     msg_id_in   = '0;
                     msg_type_in = '0;
                     time_in     = '0;
                  end else begin
                     open_frame = 1'b0;
                  end
               end
               PH_HEAD: begin
                  count_in = {11'd0, pos};
                  if (pos <= POS_SUM_END) begin
                     sum_in = sum_plus;
                  end
                  if (pos == POS_VERSION) begin
                     version_in = rx_byte;
                  end else if (pos <= POS_SOURCE_END) begin
                     source_in = {rx_byte, source_ff[47:8]};
                  end else if (pos <= POS_DEST_END) begin
                     dest_in = {rx_byte, dest_ff[47:8]};
                     if (pos == POS_DEST_END &&
                         (source_ff != cfg.host_address ||
                          dest_in != cfg.terminal_address)) begin
                        hit    = 1'b1;
                        status = ST_ADDR_BAD;
                     end
                  end else if (pos == POS_MSG_ID) begin
                     msg_id_in = rx_byte;
                  end else if (pos == POS_LEN_LO) begin
                     length_in = {length_ff[15:8], rx_byte};
                  end else if (pos == POS_LEN_HI) begin
                     length_in = {rx_byte, length_ff[7:0]};
                  end else if (pos == POS_MSG_TYPE) begin
                     msg_type_in = rx_byte;
                  end else if (pos <= POS_SUM_END) begin
                     time_in = {rx_byte, time_ff[47:8]};
                  end else if (pos == POS_HDR_CHECK) begin
                     if (sum_plus != 8'd0) begin
                        hit    = 1'b1;
                        status = ST_HDR_BAD;
                     end else begin
                        phase_in = PH_BODY;
                        count_in = '0;
                        sum_in   = '0;
                     end
                  end
               end
               PH_BODY: begin
                  if (count_ff >= length_ff) begin
                     phase_in = (sum_plus != 8'd0) ? PH_TAIL_BODYBAD : PH_TAIL_OK;
                     count_in = '0;
                  end else begin
                     sum_in   = sum_plus;
                     count_in = count_ff + 16'd1;
                  end
               end
               PH_TAIL_OK, PH_TAIL_BODYBAD, PH_TAIL_ENDBAD: begin
                  if (phase_ff == PH_TAIL_OK && rx_byte != END_MARK) begin
                     tail_phase = PH_TAIL_ENDBAD;
                  end
                  phase_in = tail_phase;
                  if (count_ff != 16'd0) begin
                     hit = 1'b1;
                     if (tail_phase == PH_TAIL_BODYBAD) begin
                        status = ST_BODY_BAD;
                     end else if (tail_phase == PH_TAIL_ENDBAD) begin
                        status = ST_END_BAD;
                     end else begin
                        status = ST_OK;
                     end
                  end else begin
                     count_in = 16'd1;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
            if (open_frame && !hit && buffer_end) begin
               hit    = 1'b1;
               status = ST_TRUNCATED;
            end
            if (hit) begin
               phase_in = PH_HUNT;
               skip_in  = !buffer_end;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         skip_ff  <= 1'b0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      source_ff   <= source_in;
      dest_ff     <= dest_in;
      length_ff   <= length_in;
      version_ff  <= version_in;
      msg_id_ff   <= msg_id_in;
      msg_type_ff <= msg_type_in;
      time_ff     <= time_in;
   end

   assign emit                = hit;
   assign result.status       = status;
   assign result.version      = version_in;
   assign result.message_id   = msg_id_in;
   assign result.message_type = msg_type_in;
   assign result.body_length  = length_in;
   assign result.frame_length = {1'b0, length_in} + FRAME_OVERHEAD;
   assign result.time_tag     = time_in;

   assign flags.hunting  = (phase_ff == PH_HUNT);
   assign flags.skipping = skip_ff;

endmodule

`default_nettype wire

>>> src/frame_checker_with_checksums_top.sv
// Top level of the frame checker: config port, byte parser and result register.
`default_nettype none

// Checks framed messages arriving one received word per cycle. Each accepted
// word is parsed in the cycle it is taken, and a frame's status word appears on
// the rsp_ channel in the cycle after the word that decides it (the last end byte,
// a failed address or header check, or the word flagged buffer_end). Sustained
// rate is one word per cycle; the single result register sets it: req_ready
// falls only while a status word is held and rsp_ready is low. After each status
// word the remaining words of the buffer are taken and dropped. Registers sit at
// byte offsets 0 (start byte), 8 (host address) and 16 (terminal address).
module frame_checker_with_checksums_top
   import fcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  req_buffer_end,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [2:0]            rsp_status,
   output      logic [7:0]            rsp_version,
   output      logic [7:0]            rsp_message_id,
   output      logic [7:0]            rsp_message_type,
   output      logic [15:0]           rsp_body_length,
   output      logic [16:0]           rsp_frame_length,
   output      logic [47:0]           rsp_time_tag,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type    cfg;
   logic       take;
   logic       emit;
   result_type result;
   flags_type  flags;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   fcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign take       = req_valid && req_ready;

   fcc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .buffer_end (req_buffer_end),
      .cfg        (cfg),
      .emit       (emit),
      .result     (result),
      .flags      (flags)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_version      = rsp_ff.version;
   assign rsp_message_id   = rsp_ff.message_id;
   assign rsp_message_type = rsp_ff.message_type;
   assign rsp_body_length  = rsp_ff.body_length;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_time_tag     = rsp_ff.time_tag;

   a_skip_only_when_hunting: assert property (@(posedge clock) disable iff (reset)
      flags.skipping |-> flags.hunting)
      else $error("skip mode outside hunting phase");

   a_new_result_from_word: assert property (@(posedge clock) disable iff (reset)
      emit |-> take)
      else $error("result produced without an accepted word");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.frame_length == ({1'b0, rsp_ff.body_length} + FRAME_OVERHEAD))
      else $error("frame length does not match body length");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status <= ST_END_BAD)
      else $error("status code out of range");

   a_result_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted result not held");

endmodule

`default_nettype wire

>>> test/frame_checker_with_checksums_top_tb.sv
// Self-checking testbench for the frame checker: random framed buffers against a byte predictor.
`timescale 1ns / 1ps

module frame_checker_with_checksums_top_tb;
   import fcc_pkg::*;

   localparam longint CYCLE_LIMIT = 600000;
   localparam int RSP_HOLD_CYCLES = 200;

   typedef enum int {
      FLAW_NONE, FLAW_SRC, FLAW_DST, FLAW_HDR, FLAW_BODY, FLAW_END1, FLAW_END2, FLAW_BODY_END
   } flaw_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       ends_buffer;
   } link_word_type;

   typedef struct {
      logic [7:0]  ver;
      logic [7:0]  mid;
      logic [7:0]  typ;
      logic [15:0] len;
      logic [47:0] stamp;
      flaw_type    flaw;
      int          cut;
      int          lead;
      int          trail;
   } frame_spec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  req_buffer_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [7:0]            rsp_version;
   logic [7:0]            rsp_message_id;
   logic [7:0]            rsp_message_type;
   logic [15:0]           rsp_body_length;
   logic [16:0]           rsp_frame_length;
   logic [47:0]           rsp_time_tag;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_checker_with_checksums_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_buffer_end   (req_buffer_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_version      (rsp_version),
      .rsp_message_id   (rsp_message_id),
      .rsp_message_type (rsp_message_type),
      .rsp_body_length  (rsp_body_length),
      .rsp_frame_length (rsp_frame_length),
      .rsp_time_tag     (rsp_time_tag),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   link_word_type word_queue[$];
   result_type    status_queue[$];
   int            mismatches = 0;
   longint        cycle_count = 0;
   int            frame_words = 0;
   int            buffers_made = 0;
   int            send_mode = 0;
   int            recv_mode = 0;
   int            send_gap = 0;
   int            rsp_stall = 0;
   int            rsp_hold_left = 0;
   bit            rsp_hold_req = 1'b0;
   bit            req_taken = 1'b0;
   bit            rsp_taken = 1'b0;

   // predictor state
   cfg_type     cfg = '{START_BYTE_RESET, 48'd0, 48'd0};
   phase_type   stage = PH_HUNT;
   bit          draining = 1'b0;
   logic [16:0] frame_pos = '0;
   logic [7:0]  run_sum = '0;
   logic [47:0] src_acc = '0;
   logic [47:0] dst_acc = '0;
   logic [15:0] len_acc = '0;
   logic [7:0]  f_version = '0;
   logic [7:0]  f_msg_id = '0;
   logic [7:0]  f_msg_type = '0;
   logic [47:0] stamp_acc = '0;

   function automatic int draw_wait(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 12);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      endcase
   endfunction

   function automatic bit close_frame(input logic [2:0] code, input logic at_end,
                                      output result_type r);
      r.status       = code;
      r.version      = f_version;
      r.message_id   = f_msg_id;
      r.message_type = f_msg_type;
      r.body_length  = len_acc;
      r.frame_length = 17'(len_acc) + FRAME_OVERHEAD;
      r.time_tag     = stamp_acc;
      stage          = PH_HUNT;
      draining       = !at_end;
      return 1'b1;
   endfunction

   function automatic bit predict_status(input logic [7:0] b, input logic at_end,
                                         output result_type r);
      logic [4:0]  pos;
      logic [7:0]  chk;
      r = '0;
      if (draining) begin
         if (at_end) draining = 1'b0;
         return 1'b0;
      end
      case (stage)
         PH_HUNT: begin
            if (b != cfg.start_byte) return 1'b0;
            frame_pos  = '0;
            run_sum    = '0;
            src_acc    = '0;
            dst_acc    = '0;
            len_acc    = '0;
            f_version  = '0;
            f_msg_id   = '0;
            f_msg_type = '0;
            stamp_acc  = '0;
            stage      = PH_HEAD;
         end
         PH_HEAD: begin
            pos = frame_pos[4:0] + 5'd1;
            frame_pos = 17'(pos);
            if (pos <= POS_SUM_END) run_sum = run_sum + b;
            if (pos == POS_VERSION) f_version = b;
            else if (pos <= POS_SOURCE_END) src_acc = {b, src_acc[47:8]};
            else if (pos <= POS_DEST_END) begin
               dst_acc = {b, dst_acc[47:8]};
               if (pos == POS_DEST_END && (src_acc != cfg.host_address ||
                                           dst_acc != cfg.terminal_address))
                  return close_frame(ST_ADDR_BAD, at_end, r);
            end
            else if (pos == POS_MSG_ID) f_msg_id = b;
            else if (pos == POS_LEN_LO) len_acc[7:0] = b;
            else if (pos == POS_LEN_HI) len_acc[15:8] = b;
            else if (pos == POS_MSG_TYPE) f_msg_type = b;
            else if (pos <= POS_SUM_END) stamp_acc = {b, stamp_acc[47:8]};
            else begin
               chk = run_sum + b;
               if (chk != 8'd0) return close_frame(ST_HDR_BAD, at_end, r);
               stage     = PH_BODY;
               frame_pos = '0;
               run_sum   = '0;
            end
         end
         PH_BODY: begin
            if (frame_pos >= 17'(len_acc)) begin
               chk       = run_sum + b;
               stage     = (chk != 8'd0) ? PH_TAIL_BODYBAD : PH_TAIL_OK;
               frame_pos = '0;
            end else begin
               run_sum   = run_sum + b;
               frame_pos = frame_pos + 17'd1;
            end
         end
         default: begin
            if (stage == PH_TAIL_OK && b != END_MARK) stage = PH_TAIL_ENDBAD;
            if (frame_pos >= 17'd1) begin
               if (stage == PH_TAIL_BODYBAD) return close_frame(ST_BODY_BAD, at_end, r);
               if (stage == PH_TAIL_ENDBAD) return close_frame(ST_END_BAD, at_end, r);
               return close_frame(ST_OK, at_end, r);
            end
            frame_pos = 17'd1;
         end
      endcase
      if (at_end) return close_frame(ST_TRUNCATED, 1'b1, r);
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      result_type want;
      result_type nxt;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** frame_checker_with_checksums_top: FAILED **");
         $finish;
      end else begin
         if (!reset && rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (status_queue.size() == 0) begin
               $error("status word with nothing expected: status %0d", rsp_status);
               mismatches++;
            end else begin
               want = status_queue.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("version", 64'(want.version), 64'(rsp_version));
               check_field("message_id", 64'(want.message_id), 64'(rsp_message_id));
               check_field("message_type", 64'(want.message_type),
                           64'(rsp_message_type));
               check_field("body_length", 64'(want.body_length), 64'(rsp_body_length));
               check_field("frame_length", 64'(want.frame_length),
                           64'(rsp_frame_length));
               check_field("time_tag", 64'(want.time_tag), 64'(rsp_time_tag));
            end
         end
         if (!reset && req_valid && req_ready) begin
            req_taken = 1'b1;
            if (predict_status(req_rx_byte, req_buffer_end, nxt)) status_queue.push_back(nxt);
         end
      end
   end

   always @(negedge clock) begin
      logic          offer;
      link_word_type w;
      offer = req_valid;
      if (req_taken) begin
         offer     = 1'b0;
         req_taken = 1'b0;
         send_gap  = draw_wait(send_mode);
      end
      if (!offer && !reset) begin
         if (send_gap > 0) send_gap--;
         else if (word_queue.size() > 0) begin
            w = word_queue.pop_front();
            req_rx_byte    <= w.rx;
            req_buffer_end <= w.ends_buffer;
            offer = 1'b1;
         end
      end
      req_valid <= offer;
   end

   always @(negedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_left = RSP_HOLD_CYCLES;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_taken) begin
         rsp_stall = draw_wait(recv_mode);
         rsp_taken = 1'b0;
      end
      if (reset) rsp_ready <= 1'b0;
      else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   task automatic csr_access(input logic [1:0] idx, input logic wr, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_register(input logic [1:0] idx, input logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] rd;
      mask  = (idx == REG_START_BYTE) ? 64'hFF : 64'hFFFF_FFFF_FFFF;
      value = value & mask;
      csr_access(idx, 1'b1, value, rd);
      csr_access(idx, 1'b0, 64'd0, rd);
      if ((rd & mask) !== value) begin
         $error("register %0d: expected %0h, got %0h", idx, value, rd & mask);
         mismatches++;
      end
      case (idx)
         REG_START_BYTE: cfg.start_byte = value[7:0];
         REG_HOST_ADDR:  cfg.host_address = value[47:0];
         default:        cfg.terminal_address = value[47:0];
      endcase
   endtask

   task automatic wait_idle();
      while (word_queue.size() != 0 || req_valid || status_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_word(input logic [7:0] b, input logic ends_buffer);
      link_word_type w;
      w.rx          = b;
      w.ends_buffer = ends_buffer;
      word_queue.push_back(w);
   endtask

   task automatic queue_noise(input int n, input bit avoid_start);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         if (avoid_start && v == cfg.start_byte) v = v ^ 8'h01;
         push_word(v, i == n - 1);
      end
   endtask

   function automatic logic [7:0] not_end_mark();
      logic [7:0] v;
      v = 8'($urandom_range(0, 254));
      return (v >= END_MARK) ? v + 8'd1 : v;
   endfunction

   function automatic frame_spec_type random_spec();
      frame_spec_type s;
      s.ver   = 8'($urandom);
      s.mid   = 8'($urandom);
      s.typ   = 8'($urandom);
      s.stamp = 48'({$urandom, $urandom});
      s.len   = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(13, 30))
                                             : 16'($urandom_range(0, 3));
      s.flaw  = FLAW_NONE;
      s.cut   = 0;
      s.lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      s.trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      return s;
   endfunction

   // cut: 0 keeps the whole frame, -1 picks a random early end, n > 0 keeps the first n bytes
   task automatic queue_buffer(input frame_spec_type s);
      logic [7:0]  fb[$];
      logic [7:0]  sum;
      logic [7:0]  v;
      logic [47:0] src;
      logic [47:0] dst;
      src = cfg.host_address;
      dst = cfg.terminal_address;
      if (s.flaw == FLAW_SRC)
         src = src ^ (48'($urandom_range(1, 255)) << (8 * $urandom_range(0, 5)));
      if (s.flaw == FLAW_DST)
         dst = dst ^ (48'($urandom_range(1, 255)) << (8 * $urandom_range(0, 5)));
      fb.push_back(cfg.start_byte);
      fb.push_back(s.ver);
      for (int i = 0; i < 6; i++) fb.push_back(src[8*i +: 8]);
      for (int i = 0; i < 6; i++) fb.push_back(dst[8*i +: 8]);
      fb.push_back(s.mid);
      fb.push_back(s.len[7:0]);
      fb.push_back(s.len[15:8]);
      fb.push_back(s.typ);
      for (int i = 0; i < 6; i++) fb.push_back(s.stamp[8*i +: 8]);
      sum = 8'd0;
      for (int i = 1; i <= 23; i++) sum = sum + fb[i];
      v = 8'd0 - sum;
      if (s.flaw == FLAW_HDR) v = v + 8'($urandom_range(1, 255));
      fb.push_back(v);
      sum = 8'd0;
      for (int i = 0; i < s.len; i++) begin
         v = 8'($urandom);
         sum = sum + v;
         fb.push_back(v);
      end
      v = 8'd0 - sum;
      if (s.flaw == FLAW_BODY || s.flaw == FLAW_BODY_END) v = v + 8'($urandom_range(1, 255));
      fb.push_back(v);
      fb.push_back((s.flaw == FLAW_END1 || s.flaw == FLAW_BODY_END) ? not_end_mark() : END_MARK);
      fb.push_back((s.flaw == FLAW_END2) ? not_end_mark() : END_MARK);
      if (s.cut < 0) s.cut = $urandom_range(1, fb.size() - 1);
      if (s.cut > 0)
         while (fb.size() > s.cut) void'(fb.pop_back());
      frame_words += fb.size();
      for (int i = 0; i < s.lead; i++) begin
         v = 8'($urandom);
         if (v == cfg.start_byte) v = v ^ 8'h01;
         push_word(v, 1'b0);
      end
      foreach (fb[i]) push_word(fb[i], i == fb.size() - 1 && (s.cut > 0 || s.trail == 0));
      if (s.cut == 0)
         for (int i = 0; i < s.trail; i++) push_word(8'($urandom), i == s.trail - 1);
   endtask

   task automatic queue_random_buffer();
      frame_spec_type s;
      int             k;
      s = random_spec();
      k = $urandom_range(0, 99);
      if (k >= 92) queue_noise($urandom_range(1, 8), 1'b0);
      else begin
         if (k >= 55) s.flaw = flaw_type'($urandom_range(1, 7));
         if (k >= 80) s.cut = -1;
         queue_buffer(s);
      end
   endtask

   initial begin
      frame_spec_type s;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers
      send_mode = 2;
      recv_mode = 2;
      s = random_spec(); s.len = 16'd0; queue_buffer(s);
      s = random_spec();
      s.ver = 8'hFF; s.mid = 8'hFF; s.typ = 8'hFF; s.stamp = '1;
      queue_buffer(s);
      s = random_spec();
      s.ver = 8'h00; s.mid = 8'h00; s.typ = 8'h00; s.stamp = '0;
      queue_buffer(s);
      for (int f = FLAW_SRC; f <= FLAW_BODY_END; f++) begin
         s = random_spec(); s.flaw = flaw_type'(f); queue_buffer(s);
      end
      s = random_spec(); s.flaw = FLAW_DST; s.cut = 14; queue_buffer(s);
      s = random_spec(); s.flaw = FLAW_HDR; s.len = 16'hFFFF; s.cut = 25; queue_buffer(s);
      s = random_spec(); s.cut = 1; queue_buffer(s);
      s = random_spec(); s.cut = 10; queue_buffer(s);
      s = random_spec(); s.len = 16'd6; s.cut = 28; queue_buffer(s);
      s = random_spec(); s.len = 16'd3; s.cut = 29; queue_buffer(s);
      s = random_spec(); s.len = 16'd3; s.cut = 30; queue_buffer(s);
      queue_noise(6, 1'b1);
      s = random_spec(); s.lead = 3; s.trail = 4; queue_buffer(s);
      s = random_spec(); s.flaw = FLAW_SRC; s.trail = 3; queue_buffer(s);
      wait_idle();

      set_register(REG_START_BYTE, 64'h00);
      set_register(REG_HOST_ADDR, 64'hFFFF_FFFF_FFFF);
      set_register(REG_TERM_ADDR, 64'h0);
      send_mode = 1;
      recv_mode = 1;
      repeat (1) queue_random_buffer();
      wait_idle();

      set_register(REG_START_BYTE, 64'hFF);
      set_register(REG_HOST_ADDR, 64'h0);
      set_register(REG_TERM_ADDR, 64'hFFFF_FFFF_FFFF);
      send_mode = 0;
      recv_mode = 2;
      repeat (1) queue_random_buffer();
      s = random_spec(); s.len = 16'd300; s.flaw = FLAW_NONE; s.cut = 40; queue_buffer(s);
      wait_idle();

      // hold off the result side so the block backs up into its input
      send_mode = 0;
      recv_mode = 0;
      rsp_hold_req = 1'b1;
      repeat (24) push_word(cfg.start_byte, 1'b1);
      wait_idle();

      while (frame_words < 600 || buffers_made < 4) begin
         if (buffers_made % 12 == 0) begin
            wait_idle();
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 1)) set_register(REG_START_BYTE, 64'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) set_register(REG_HOST_ADDR, {$urandom, $urandom});
            if ($urandom_range(0, 1)) set_register(REG_TERM_ADDR, {$urandom, $urandom});
         end
         queue_random_buffer();
         buffers_made++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("** frame_checker_with_checksums_top: PASSED **");
      end else begin
         $display("** frame_checker_with_checksums_top: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
src/fcc_pkg.sv
src/fcc_csr.sv
src/fcc_parser.sv
src/frame_checker_with_checksums_top.sv
test/frame_checker_with_checksums_top_tb.sv
